FILE: rtl/mmfq_pkg.sv
// Shared constants and types for the min-max feature quantizer.
// No dependencies; imported by minmax_feature_quantizer_core.
`default_nettype none

package mmfq_pkg;

	localparam int MAX_DIMS_DEF = 64;

	localparam int IDX_W  = 6;
	localparam int VAL_W  = 32;
	localparam int CODE_W = 16;
	localparam int CFG_W  = 7;

	localparam logic [CFG_W-1:0] ACTIVE_DIMS_RST = 7'd64;

	// Empty range: min at the top of Q16.16, max at the bottom.
	localparam logic [VAL_W-1:0] MIN_RST = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] MAX_RST = 32'h8000_0000;

	localparam logic [VAL_W-1:0]  ONE_Q16   = 32'h0001_0000;
	localparam logic [CODE_W-1:0] CODE_FULL = 16'hFFFF;

	typedef enum logic [1:0] {
		ACT_CLEAR      = 2'd0,
		ACT_OBSERVE    = 2'd1,
		ACT_QUANTIZE   = 2'd2,
		ACT_DEQUANTIZE = 2'd3
	} action_t;

	typedef enum logic {
		ST_OK        = 1'b0,
		ST_BAD_INDEX = 1'b1
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/mmfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the per-dimension range store.
`default_nettype none

module mmfq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/minmax_feature_quantizer_core.sv
// Min-max 16-bit feature quantizer, top level.
// Depends on mmfq_pkg and mmfq_ram.
`default_nettype none

// Keeps a Q16.16 minimum and maximum per feature dimension in one RAM
// ({max, min} per word) and serves one command transaction at a time: clear,
// observe, quantize or dequantize. A command is taken when start is high and
// busy is low; exactly one result follows, shown for a single cycle with done
// high. The receiver cannot stall, so capture the result on that cycle.
// Quantize saturates the code or runs the 16-step restoring divider, one
// quotient bit per cycle; dequantize multiplies, then runs a short fold that
// divides by 65535; clear rewrites the RAM one entry per cycle. An index out
// of range ends the command with a bad-index status.
// After reset the same sweep runs with busy high.
// cfg_ready is always high; write active_dims only while no command is open.

module minmax_feature_quantizer_core #(
	parameter int MAX_DIMS = mmfq_pkg::MAX_DIMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          action,
	input  logic [mmfq_pkg::IDX_W-1:0]          dim_index,
	input  logic signed [mmfq_pkg::VAL_W-1:0]   sample_value,
	input  logic [mmfq_pkg::CODE_W-1:0]         code_in,
	// result channel
	output logic                                done,
	output logic                                status,
	output logic [mmfq_pkg::CODE_W-1:0]         quantized_code,
	output logic signed [mmfq_pkg::VAL_W-1:0]   value_out,
	output logic signed [mmfq_pkg::VAL_W-1:0]   range_min,
	output logic signed [mmfq_pkg::VAL_W-1:0]   range_max,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mmfq_pkg::CFG_W-1:0]          cfg_data
);

	import mmfq_pkg::*;

	localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DW = 2 * VAL_W;

	typedef enum logic [10:0] {
		S_INIT  = 11'b000_0000_0001,  // post-reset RAM sweep
		S_IDLE  = 11'b000_0000_0010,
		S_CLR   = 11'b000_0000_0100,  // clear command sweep
		S_CALC  = 11'b000_0000_1000,  // RAM data back, observe write
		S_QPREP = 11'b000_0001_0000,
		S_QSAT  = 11'b000_0010_0000,
		S_QDIV  = 11'b000_0100_0000,
		S_DPREP = 11'b000_1000_0000,
		S_DABS  = 11'b001_0000_0000,
		S_DFOLD = 11'b010_0000_0000,
		S_DVAL  = 11'b100_0000_0000
	} state_t;

	state_t                state_q;
	logic [CFG_W-1:0]      active_dims_q;
	logic [AW-1:0]         sweep_q;

	// captured command
	action_t               act_q;
	logic [IDX_W-1:0]      idx_q;
	logic signed [VAL_W-1:0] x_q;
	logic [CODE_W-1:0]     code_q;

	// range after the action
	logic signed [VAL_W-1:0] lo_q;
	logic signed [VAL_W:0]   range_q;
	logic signed [VAL_W:0]   diff_q;

	// quantize divider
	logic [47:0]           num_q;
	logic [VAL_W-1:0]      dvsr_q;
	logic [VAL_W-1:0]      rem_q;
	logic [CODE_W-1:0]     quo_q;
	logic [CODE_W-1:0]     bits_q;
	logic [3:0]            step_q;

	// dequantize
	logic signed [49:0]    prod_q;
	logic                  neg_q;
	logic [48:0]           t_q;
	logic [33:0]           qacc_q;

	// result registers
	logic                  done_q;
	logic                  status_q;
	logic [CODE_W-1:0]     qcode_q;
	logic [VAL_W-1:0]      vout_q;
	logic [VAL_W-1:0]      rmin_q;
	logic [VAL_W-1:0]      rmax_q;

	// RAM
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DW-1:0]         ram_wdata;
	logic [DW-1:0]         ram_rdata;

	logic                  accept;
	logic                  in_range;
	logic                  sweep_last;

	logic signed [VAL_W-1:0] lo_cur, hi_cur, lo_new, hi_new;
	logic signed [VAL_W:0]   range_d, diff_d;
	logic                  range_small, diff_nonpos;
	logic [47:0]           num_d;
	logic [VAL_W:0]        div_tmp;
	logic                  div_ge;
	logic [VAL_W-1:0]      rem_nxt;
	logic signed [49:0]    prod_d;
	logic [49:0]           uabs_d;
	logic [34:0]           qs_d;
	logic [35:0]           v_d;
	logic [VAL_W-1:0]      vsat_d;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign in_range  = ({1'b0, dim_index} < active_dims_q) && (32'(dim_index) < MAX_DIMS);
	assign sweep_last = (sweep_q == AW'(MAX_DIMS - 1));

	assign done           = done_q;
	assign status         = status_q;
	assign quantized_code = qcode_q;
	assign value_out      = vout_q;
	assign range_min      = rmin_q;
	assign range_max      = rmax_q;

	// ---------------------------------------------------------------------
	// Range store: write during sweeps and on observe, read at accept.
	// Commands are strictly serialized, so a read never overlaps a write to
	// the same entry.
	// ---------------------------------------------------------------------
	assign lo_cur = ram_rdata[VAL_W-1:0];
	assign hi_cur = ram_rdata[DW-1:VAL_W];
	assign lo_new = ((act_q == ACT_OBSERVE) && (x_q < lo_cur)) ? x_q : lo_cur;
	assign hi_new = ((act_q == ACT_OBSERVE) && (x_q > hi_cur)) ? x_q : hi_cur;

	always_comb begin
		if (state_q == S_INIT || state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = {MAX_RST, MIN_RST};
		end else begin
			ram_we    = (state_q == S_CALC) && (act_q == ACT_OBSERVE);
			ram_waddr = AW'(idx_q);
			ram_wdata = {hi_new, lo_new};
		end
	end

	mmfq_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_DIMS)
	) u_range_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (AW'(dim_index)),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------------
	// Datapath helpers
	// ---------------------------------------------------------------------
	// range = max - min and d = x - min, both 33-bit signed
	assign range_d     = {hi_new[VAL_W-1], hi_new} - {lo_new[VAL_W-1], lo_new};
	assign diff_d      = {x_q[VAL_W-1], x_q} - {lo_new[VAL_W-1], lo_new};
	assign range_small = range_q[VAL_W] || (range_q == '0);
	assign diff_nonpos = diff_q[VAL_W] || (diff_q == '0);

	// d * 65535 = (d << 16) - d; d is positive and fits 32 bits here
	assign num_d = diff_nonpos ? '0
	             : ({diff_q[VAL_W-1:0], 16'h0000} - {16'h0000, diff_q[VAL_W-1:0]});

	// one restoring step
	assign div_tmp = {rem_q, bits_q[CODE_W-1]};
	assign div_ge  = (div_tmp >= {1'b0, dvsr_q});
	assign rem_nxt = div_ge ? VAL_W'(div_tmp - {1'b0, dvsr_q}) : div_tmp[VAL_W-1:0];

	// code * range, 17x33 signed
	assign prod_d = $signed({1'b0, code_q}) * range_q;

	// floor division toward minus infinity: divide |p| + 65534 when negative
	assign uabs_d = prod_q[49] ? ((~prod_q) + 50'd1 + 50'd65534) : prod_q;

	// min + q with saturation to 32 bits
	assign qs_d   = neg_q ? ((~{1'b0, qacc_q}) + 35'd1) : {1'b0, qacc_q};
	assign v_d    = {{4{lo_q[VAL_W-1]}}, lo_q} + {qs_d[34], qs_d};
	assign vsat_d = (v_d[35:31] == 5'b00000 || v_d[35:31] == 5'b11111) ? v_d[VAL_W-1:0]
	              : (v_d[35] ? MAX_RST : MIN_RST);

	// ---------------------------------------------------------------------
	// Configuration
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_dims_q <= ACTIVE_DIMS_RST;
		end else if (cfg_valid && cfg_ready) begin
			active_dims_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------------
	// Control
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (!in_range) begin
							done_q <= 1'b1;
						end else if (action_t'(action) == ACT_CLEAR) begin
							sweep_q <= '0;
							state_q <= S_CLR;
						end else begin
							state_q <= S_CALC;
						end
					end
				end
				S_CLR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_last) begin
						sweep_q <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CALC: begin
					case (act_q)
						ACT_QUANTIZE:   state_q <= S_QPREP;
						ACT_DEQUANTIZE: state_q <= S_DPREP;
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_QPREP: state_q <= S_QSAT;
				S_QSAT: begin
					if (num_q >= {dvsr_q, 16'h0000}) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_QDIV;
					end
				end
				S_QDIV: begin
					if (step_q == 4'd0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DPREP: state_q <= S_DABS;
				S_DABS:  state_q <= S_DFOLD;
				S_DFOLD: begin
					if (t_q[48:16] == '0) begin
						state_q <= S_DVAL;
					end
				end
				S_DVAL: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q  <= action_t'(action);
				idx_q  <= dim_index;
				x_q    <= sample_value;
				code_q <= code_in;
				if (accept && !in_range) begin
					status_q <= ST_BAD_INDEX;
					qcode_q  <= '0;
					vout_q   <= '0;
					rmin_q   <= '0;
					rmax_q   <= '0;
				end
			end
			S_CLR: begin
				if (sweep_last) begin
					status_q <= ST_OK;
					qcode_q  <= '0;
					vout_q   <= '0;
					rmin_q   <= MIN_RST;
					rmax_q   <= MAX_RST;
				end
			end
			S_CALC: begin
				lo_q    <= lo_new;
				range_q <= range_d;
				diff_q  <= diff_d;
				// observe reports here; other actions overwrite later
				status_q <= ST_OK;
				qcode_q  <= '0;
				vout_q   <= '0;
				rmin_q   <= lo_new;
				rmax_q   <= hi_new;
			end
			S_QPREP: begin
				num_q  <= num_d;
				dvsr_q <= range_small ? ONE_Q16 : range_q[VAL_W-1:0];
			end
			S_QSAT: begin
				rem_q  <= num_q[47:16];
				bits_q <= num_q[15:0];
				quo_q  <= '0;
				step_q <= 4'd15;
				if (num_q >= {dvsr_q, 16'h0000}) begin
					qcode_q <= CODE_FULL;
				end
			end
			S_QDIV: begin
				rem_q  <= rem_nxt;
				bits_q <= {bits_q[CODE_W-2:0], 1'b0};
				quo_q  <= {quo_q[CODE_W-2:0], div_ge};
				step_q <= step_q - 4'd1;
				if (step_q == 4'd0) begin
					qcode_q <= {quo_q[CODE_W-2:0], div_ge};
				end
			end
			S_DPREP: begin
				prod_q <= prod_d;
			end
			S_DABS: begin
				neg_q  <= prod_q[49];
				t_q    <= uabs_d[48:0];
				qacc_q <= '0;
			end
			S_DFOLD: begin
				// u = a*65536 + b  ->  u/65535 = a + (a + b)/65535
				if (t_q[48:16] == '0) begin
					qacc_q <= qacc_q + {33'b0, (t_q[15:0] == CODE_FULL)};
				end else begin
					qacc_q <= qacc_q + 34'(t_q[48:16]);
					t_q    <= 49'(t_q[48:16]) + 49'(t_q[15:0]);
				end
			end
			S_DVAL: begin
				vout_q <= vsat_d;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
